// ===== design/slsm_pkg.sv =====
package slsm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] OP_MERGE = 2'd0;
    localparam logic [1:0] OP_UNION = 2'd1;
    localparam logic [1:0] OP_INTER = 2'd2;
    localparam logic [1:0] OP_DIFF  = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_list_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_list_stat;

endpackage

// ===== design/slsm_cell.sv =====
module slsm_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_shift,
    input  slsm_pkg::t_data i_load_data,
    input  slsm_pkg::t_data i_next_data,
    output slsm_pkg::t_data o_data
);
    import slsm_pkg::*;

    t_data r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_next_data;
        end else if (i_load) begin
            r_value <= i_load_data;
        end
    end

    assign o_data = r_value;

endmodule

// ===== design/slsm_list.sv =====
module slsm_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slsm_pkg::t_list_ctrl i_ctrl,
    input  slsm_pkg::t_data      i_push_data,
    output slsm_pkg::t_data      o_head,
    output slsm_pkg::t_list_stat o_stat
);
    import slsm_pkg::*;

    t_cnt  r_cnt;
    t_cnt  n_cnt;
    t_data w_cell [LIST_DEPTH];
    t_data w_next [LIST_DEPTH];

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.clear) begin
            n_cnt = '0;
        end else if (i_ctrl.push && !o_stat.full) begin
            n_cnt = r_cnt + t_cnt'(1);
        end else if (i_ctrl.pop && !o_stat.empty) begin
            n_cnt = r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            if (g == LIST_DEPTH - 1) begin : g_tail
                assign w_next[g] = w_cell[g];
            end else begin : g_mid
                assign w_next[g] = w_cell[g+1];
            end

            slsm_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (i_ctrl.push && !i_ctrl.clear && (r_cnt == t_cnt'(g))),
                .i_shift     (i_ctrl.pop && !i_ctrl.clear),
                .i_load_data (i_push_data),
                .i_next_data (w_next[g]),
                .o_data      (w_cell[g])
            );
        end
    endgenerate

    assign o_head       = w_cell[0];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == t_cnt'(LIST_DEPTH));

endmodule

// ===== design/sorted_list_set_merge.sv =====
// Channel   Dir  Request fields
// s_axis    in   tdata: element; tuser: list_select, has_element; tlast: finish
// m_axis    out  tdata: result_value; tuser: result_empty, overflow_seen;
//                tlast: result_last
// cfg       in   i_cfg_wr_data: set_operation, written when i_cfg_wr_en is high
//
// Requests are taken only while idle. A finish request starts a two-pointer
// walk of steps (at most the sum of both list counts) followed by a closing
// step; no new request is taken until it ends. Each step shifts the chain of
// cells of one or both lists by one place. Reset is synchronous and active low;
// it clears both counts, the drop flag and the operation. A stalled output
// register holds the walk in place.
module sorted_list_set_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [slsm_pkg::DATA_WIDTH-1:0] s_axis_tdata,  // element
    input  logic [1:0]                    s_axis_tuser,  // list_select, has_element
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [slsm_pkg::DATA_WIDTH-1:0] m_axis_tdata,  // result_value
    output logic [1:0]                    m_axis_tuser,  // result_empty, overflow_seen
    output logic                          m_axis_tlast
);
    import slsm_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0] r_state, n_state;
    logic [1:0] r_set_op;
    logic       r_dropped, n_dropped;
    logic       r_pend_valid, n_pend_valid;
    t_data      r_pend_value, n_pend_value;
    logic       r_out_valid, n_out_valid;
    t_data      r_out_value, n_out_value;
    logic       r_out_last, n_out_last;
    logic       r_out_empty, n_out_empty;
    logic       r_out_ovf, n_out_ovf;

    t_list_ctrl ctrl_a, ctrl_b;
    t_list_stat stat_a, stat_b;
    t_data      head_a, head_b;

    logic  out_free;
    logic  step_emit;
    t_data step_value;
    logic  step_pop_a;
    logic  step_pop_b;
    logic  step_done;

    slsm_list u_list_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_a),
        .i_push_data (t_data'(s_axis_tdata)),
        .o_head      (head_a),
        .o_stat      (stat_a)
    );

    slsm_list u_list_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_b),
        .i_push_data (t_data'(s_axis_tdata)),
        .o_head      (head_b),
        .o_stat      (stat_b)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        step_emit  = 1'b0;
        step_value = head_a;
        step_pop_a = 1'b0;
        step_pop_b = 1'b0;
        step_done  = 1'b0;
        if (!stat_a.empty && !stat_b.empty) begin
            if (head_a < head_b) begin
                step_emit  = (r_set_op != OP_INTER);
                step_pop_a = 1'b1;
            end else if (head_b < head_a) begin
                step_emit  = (r_set_op == OP_MERGE) || (r_set_op == OP_UNION);
                step_value = head_b;
                step_pop_b = 1'b1;
            end else if (r_set_op == OP_MERGE) begin
                step_emit  = 1'b1;
                step_value = head_b;
                step_pop_b = 1'b1;
            end else begin
                step_emit  = (r_set_op == OP_UNION) || (r_set_op == OP_INTER);
                step_pop_a = 1'b1;
                step_pop_b = 1'b1;
            end
        end else if (!stat_a.empty && (r_set_op != OP_INTER)) begin
            step_emit  = 1'b1;
            step_pop_a = 1'b1;
        end else if (!stat_b.empty &&
                     ((r_set_op == OP_MERGE) || (r_set_op == OP_UNION))) begin
            step_emit  = 1'b1;
            step_value = head_b;
            step_pop_b = 1'b1;
        end else begin
            step_done = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_dropped    = r_dropped;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;
        ctrl_a       = '0;
        ctrl_b       = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[1]) begin
                        if (!s_axis_tuser[0]) begin
                            if (stat_a.full) begin
                                n_dropped = 1'b1;
                            end else begin
                                ctrl_a.push = 1'b1;
                            end
                        end else begin
                            if (stat_b.full) begin
                                n_dropped = 1'b1;
                            end else begin
                                ctrl_b.push = 1'b1;
                            end
                        end
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (step_done) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = r_pend_valid ? r_pend_value : '0;
                        n_out_last   = 1'b1;
                        n_out_empty  = !r_pend_valid;
                        n_out_ovf    = r_dropped;
                        n_pend_valid = 1'b0;
                        n_dropped    = 1'b0;
                        ctrl_a.clear = 1'b1;
                        ctrl_b.clear = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        ctrl_a.pop = step_pop_a;
                        ctrl_b.pop = step_pop_b;
                        if (step_emit) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out_value = r_pend_value;
                                n_out_last  = 1'b0;
                                n_out_empty = 1'b0;
                                n_out_ovf   = r_dropped;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_value = step_value;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_set_op     <= OP_MERGE;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dropped    <= n_dropped;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_set_op <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_value <= n_pend_value;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
        r_out_ovf    <= n_out_ovf;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = {r_out_ovf, r_out_empty};
    assign m_axis_tlast  = r_out_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty result without last mark");

    a_lists_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_RUN && r_state == ST_IDLE) |-> (stat_a.empty && stat_b.empty))
        else $error("lists not cleared after combine");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending result left while idle");

endmodule
